@@ rtl/mics_pkg.sv @@
package mics_pkg;

    typedef struct packed {
        logic        kind;
        logic [31:0] instr_word;
        logic [31:0] read_data;
    } t_in;

    typedef struct packed {
        logic [28:0] fetch_addr;
        logic [1:0]  mem_op;
        logic [28:0] mem_addr;
        logic [1:0]  mem_size;
        logic [31:0] write_data;
        logic [3:0]  byte_mask;
        logic        exc_flag;
        logic [2:0]  exc_kind;
        logic        exc_halted;
    } t_out;

    localparam int GPR_DEPTH = 32;
    localparam int GPR_WIDTH = 32;

    localparam logic [31:0] RESET_PC = 32'hBFC0_0000;
    localparam logic [31:0] EXC_VEC  = 32'h8000_0080;

    localparam logic [4:0] CP_BADA  = 5'd8;
    localparam logic [4:0] CP_SR    = 5'd12;
    localparam logic [4:0] CP_CAUSE = 5'd13;
    localparam logic [4:0] CP_EPC   = 5'd14;
    localparam int         SR_ISC_BIT = 16;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_COP0    = 6'd16;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LWL     = 6'd34;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_LWR     = 6'd38;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SWL     = 6'd42;
    localparam logic [5:0] OP_SW      = 6'd43;
    localparam logic [5:0] OP_SWR     = 6'd46;

    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_BREAK   = 6'd13;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MTHI    = 6'd17;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MTLO    = 6'd19;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DIVU    = 6'd27;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;
    localparam logic [5:0] FN_SLTU    = 6'd43;
    localparam logic [5:0] FN_RFE     = 6'd16;

    localparam logic [4:0] RS_MFC0 = 5'd0;
    localparam logic [4:0] RS_MTC0 = 5'd4;

    localparam logic [2:0] LK_LB  = 3'd0;
    localparam logic [2:0] LK_LBU = 3'd1;
    localparam logic [2:0] LK_LH  = 3'd2;
    localparam logic [2:0] LK_LHU = 3'd3;
    localparam logic [2:0] LK_LW  = 3'd4;
    localparam logic [2:0] LK_LWL = 3'd5;
    localparam logic [2:0] LK_LWR = 3'd6;

    localparam logic [2:0] EK_ADEL = 3'd0;
    localparam logic [2:0] EK_ADES = 3'd1;
    localparam logic [2:0] EK_SYS  = 3'd2;
    localparam logic [2:0] EK_BP   = 3'd3;
    localparam logic [2:0] EK_RI   = 3'd4;
    localparam logic [2:0] EK_OVF  = 3'd5;

    localparam logic [1:0] MOP_NONE  = 2'd0;
    localparam logic [1:0] MOP_READ  = 2'd1;
    localparam logic [1:0] MOP_WRITE = 2'd2;

    localparam logic [1:0] MSZ_BYTE = 2'd0;
    localparam logic [1:0] MSZ_HALF = 2'd1;
    localparam logic [1:0] MSZ_WORD = 2'd2;

    function automatic logic [3:0] exc_code(input logic [2:0] k);
        logic [3:0] c;
        unique case (k)
            EK_ADEL: c = 4'd4;
            EK_ADES: c = 4'd5;
            EK_SYS:  c = 4'd8;
            EK_BP:   c = 4'd9;
            EK_RI:   c = 4'd10;
            default: c = 4'd12;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/mics_ram.sv @@
module mics_ram #(
    parameter int W = 32,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/mips1_integer_core_step_unit.sv @@
// Instruction word: S_RS, S_RT, S_EXEC, S_WB, S_FL, S_OUT; a DIV/DIVU using the 32-step
//   divider adds S_DIV, S_DIVF after S_EXEC. Load data word: S_RS, S_LEX, S_WB, S_FL,
//   S_OUT. An ignored word goes straight to S_OUT. One word in flight at a time; the GPR
//   RAM (two-port): reads rs then rt, writes the result then the load-delay slot.
// Reset (i_rst_n low, synchronous): PC to the boot vector, HI/LO, CP0, slots, GPR
//   valid bits and halt mask cleared; GPR RAM contents read as zero until written.
module mips1_integer_core_step_unit
    import mics_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_RS, S_RT, S_EXEC, S_DIV, S_DIVF, S_LEX, S_WB, S_FL, S_OUT
    } t_state;

    t_state      r_state;
    logic [12:0] r_hmask;
    logic [31:0] r_pc, r_npc, r_hi, r_lo;
    logic [31:0] r_cp0 [32];
    logic [4:0]  r_nld_dst;
    logic [31:0] r_nld_val;
    logic        r_await;
    logic [9:0]  r_linfo;
    logic [31:0] r_gval;
    logic [4:0]  r_raddr;
    logic [31:0] r_ir, r_ld, r_a, r_b;
    logic        r_ldpath;
    logic        r_wb_en, r_fl_en;
    logic [4:0]  r_wb_addr, r_fl_addr;
    logic [31:0] r_wb_data, r_fl_data;
    logic [31:0] r_dq, r_dvs, r_rem;
    logic [4:0]  r_cnt;
    logic        r_qneg, r_rneg;
    t_out        r_res, r_out;
    logic        r_ov;

    logic        ram_we;
    logic [4:0]  ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata, rv;

    mics_ram #(.W(GPR_WIDTH), .D(GPR_DEPTH)) u_gpr (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rv = r_gval[r_raddr] ? ram_rdata : '0;

    always_comb begin
        ram_raddr = '0;
        if (r_state == S_IDLE) begin
            ram_raddr = i_in.kind ? r_linfo[7:3] : i_in.instr_word[25:21];
        end else if (r_state == S_RS) begin
            ram_raddr = r_ir[20:16];
        end
        ram_we    = (r_state == S_WB && r_wb_en) || (r_state == S_FL && r_fl_en);
        ram_waddr = (r_state == S_WB) ? r_wb_addr : r_fl_addr;
        ram_wdata = (r_state == S_WB) ? r_wb_data : r_fl_data;
    end

    // decode / execute
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa, shamt;
    logic [15:0] imm;
    logic [31:0] simm, btgt, va, sum, link, a, b;
    logic [1:0]  lane;
    logic        x_wb_en, x_exc, x_ld, x_hi_we, x_lo_we, x_mul, x_div, x_cp_we, x_rfe;
    logic [4:0]  x_wb_addr, x_cp_idx;
    logic [31:0] x_wb_data, x_npc, x_bad, x_hi, x_lo, x_wdata, x_cp_data;
    logic [2:0]  x_ek, x_lk;
    logic [1:0]  x_mop, x_msize;
    logic [28:0] x_maddr;
    logic [3:0]  x_bmask;
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;

    assign a     = r_a;
    assign b     = r_b;
    assign op    = r_ir[31:26];
    assign rs    = r_ir[25:21];
    assign rt    = r_ir[20:16];
    assign rd    = r_ir[15:11];
    assign sa    = r_ir[10:6];
    assign fn    = r_ir[5:0];
    assign imm   = r_ir[15:0];
    assign simm  = {{16{imm[15]}}, imm};
    assign btgt  = r_pc + 32'd4 + {simm[29:0], 2'b00};
    assign va    = a + simm;
    assign lane  = va[1:0];
    assign link  = r_pc + 32'd8;
    assign shamt = fn[2] ? a[4:0] : sa;
    assign ma    = $signed({(fn == FN_MULT) & a[31], a});
    assign mb    = $signed({(fn == FN_MULT) & b[31], b});
    assign prod  = ma * mb;

    always_comb begin
        x_wb_en = 1'b0; x_wb_addr = rd; x_wb_data = '0;
        x_npc = r_npc + 32'd4;
        x_exc = 1'b0; x_ek = EK_RI; x_bad = '0;
        x_ld = 1'b0; x_lk = LK_LB;
        x_mop = MOP_NONE; x_maddr = '0; x_msize = MSZ_BYTE; x_wdata = '0; x_bmask = '0;
        x_hi_we = 1'b0; x_lo_we = 1'b0; x_hi = '0; x_lo = '0;
        x_mul = 1'b0; x_div = 1'b0;
        x_cp_we = 1'b0; x_cp_idx = rd; x_cp_data = b; x_rfe = 1'b0;
        sum = '0;
        unique case (op)
            OP_SPECIAL: begin
                unique case (fn)
                    FN_SLL, FN_SLLV: begin
                        x_wb_en = 1'b1; x_wb_data = b << shamt;
                    end
                    FN_SRL, FN_SRLV: begin
                        x_wb_en = 1'b1; x_wb_data = b >> shamt;
                    end
                    FN_SRA, FN_SRAV: begin
                        x_wb_en = 1'b1; x_wb_data = 32'($signed(b) >>> shamt);
                    end
                    FN_JR, FN_JALR: begin
                        if (fn == FN_JALR) begin
                            x_wb_en = 1'b1; x_wb_data = link;
                        end
                        if (a[1:0] != 2'b00) begin
                            x_exc = 1'b1; x_ek = EK_ADEL; x_bad = a;
                        end else begin
                            x_npc = a;
                        end
                    end
                    FN_SYSCALL: begin
                        x_exc = 1'b1; x_ek = EK_SYS;
                    end
                    FN_BREAK: begin
                        x_exc = 1'b1; x_ek = EK_BP;
                    end
                    FN_MFHI: begin
                        x_wb_en = 1'b1; x_wb_data = r_hi;
                    end
                    FN_MTHI: begin
                        x_hi_we = 1'b1; x_hi = a;
                    end
                    FN_MFLO: begin
                        x_wb_en = 1'b1; x_wb_data = r_lo;
                    end
                    FN_MTLO: begin
                        x_lo_we = 1'b1; x_lo = a;
                    end
                    FN_MULT, FN_MULTU: x_mul = 1'b1;
                    FN_DIV: begin
                        x_hi_we = 1'b1; x_lo_we = 1'b1;
                        if (b == '0) begin
                            x_lo = a[31] ? 32'd1 : 32'hFFFF_FFFF; x_hi = a;
                        end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                            x_lo = 32'h8000_0000; x_hi = '0;
                        end else begin
                            x_hi_we = 1'b0; x_lo_we = 1'b0; x_div = 1'b1;
                        end
                    end
                    FN_DIVU: begin
                        if (b == '0) begin
                            x_hi_we = 1'b1; x_lo_we = 1'b1;
                            x_lo = 32'hFFFF_FFFF; x_hi = a;
                        end else begin
                            x_div = 1'b1;
                        end
                    end
                    FN_ADD: begin
                        sum = a + b;
                        if (a[31] == b[31] && sum[31] != a[31]) begin
                            x_exc = 1'b1; x_ek = EK_OVF;
                        end else begin
                            x_wb_en = 1'b1; x_wb_data = sum;
                        end
                    end
                    FN_ADDU: begin
                        x_wb_en = 1'b1; x_wb_data = a + b;
                    end
                    FN_SUB: begin
                        sum = a - b;
                        if (a[31] != b[31] && sum[31] != a[31]) begin
                            x_exc = 1'b1; x_ek = EK_OVF;
                        end else begin
                            x_wb_en = 1'b1; x_wb_data = sum;
                        end
                    end
                    FN_SUBU: begin
                        x_wb_en = 1'b1; x_wb_data = a - b;
                    end
                    FN_AND: begin
                        x_wb_en = 1'b1; x_wb_data = a & b;
                    end
                    FN_OR: begin
                        x_wb_en = 1'b1; x_wb_data = a | b;
                    end
                    FN_XOR: begin
                        x_wb_en = 1'b1; x_wb_data = a ^ b;
                    end
                    FN_NOR: begin
                        x_wb_en = 1'b1; x_wb_data = ~(a | b);
                    end
                    FN_SLT: begin
                        x_wb_en = 1'b1; x_wb_data = {31'b0, $signed(a) < $signed(b)};
                    end
                    FN_SLTU: begin
                        x_wb_en = 1'b1; x_wb_data = {31'b0, a < b};
                    end
                    default: begin
                        x_exc = 1'b1; x_ek = EK_RI;
                    end
                endcase
            end
            OP_REGIMM: begin
                if (rt[4:1] == 4'b1000) begin
                    x_wb_en = 1'b1; x_wb_addr = 5'd31; x_wb_data = link;
                end
                if (a[31] ^ rt[0]) x_npc = btgt;
            end
            OP_J, OP_JAL: begin
                if (op == OP_JAL) begin
                    x_wb_en = 1'b1; x_wb_addr = 5'd31; x_wb_data = link;
                end
                x_npc = {btgt[31:28] & 4'h0 | (r_pc[31:28] + {3'b0, &r_pc[27:2]}),
                         r_ir[25:0], 2'b00};
            end
            OP_BEQ:  if (a == b) x_npc = btgt;
            OP_BNE:  if (a != b) x_npc = btgt;
            OP_BLEZ: if (a[31] || a == '0) x_npc = btgt;
            OP_BGTZ: if (!a[31] && a != '0) x_npc = btgt;
            OP_ADDI: begin
                x_wb_addr = rt;
                if (a[31] == simm[31] && va[31] != a[31]) begin
                    x_exc = 1'b1; x_ek = EK_OVF;
                end else begin
                    x_wb_en = 1'b1; x_wb_data = va;
                end
            end
            OP_ADDIU: begin
                x_wb_addr = rt; x_wb_en = 1'b1; x_wb_data = va;
            end
            OP_SLTI: begin
                x_wb_addr = rt; x_wb_en = 1'b1;
                x_wb_data = {31'b0, $signed(a) < $signed(simm)};
            end
            OP_SLTIU: begin
                x_wb_addr = rt; x_wb_en = 1'b1; x_wb_data = {31'b0, a < simm};
            end
            OP_ANDI: begin
                x_wb_addr = rt; x_wb_en = 1'b1; x_wb_data = a & {16'b0, imm};
            end
            OP_ORI: begin
                x_wb_addr = rt; x_wb_en = 1'b1; x_wb_data = a | {16'b0, imm};
            end
            OP_XORI: begin
                x_wb_addr = rt; x_wb_en = 1'b1; x_wb_data = a ^ {16'b0, imm};
            end
            OP_LUI: begin
                x_wb_addr = rt; x_wb_en = 1'b1; x_wb_data = {imm, 16'b0};
            end
            OP_COP0: begin
                if (rs == RS_MFC0) begin
                    x_wb_addr = rt; x_wb_en = 1'b1; x_wb_data = r_cp0[rd];
                end else if (rs == RS_MTC0) begin
                    x_cp_we = 1'b1;
                end else if (fn == FN_RFE) begin
                    x_rfe = 1'b1;
                end else begin
                    x_exc = 1'b1; x_ek = EK_RI;
                end
            end
            OP_LB, OP_LBU: begin
                x_ld = 1'b1; x_lk = (op == OP_LB) ? LK_LB : LK_LBU;
                x_msize = MSZ_BYTE; x_maddr = va[28:0];
            end
            OP_LH, OP_LHU: begin
                if (va[0]) begin
                    x_exc = 1'b1; x_ek = EK_ADEL; x_bad = va;
                end else begin
                    x_ld = 1'b1; x_lk = (op == OP_LH) ? LK_LH : LK_LHU;
                    x_msize = MSZ_HALF; x_maddr = va[28:0];
                end
            end
            OP_LW: begin
                if (va[1:0] != 2'b00) begin
                    x_exc = 1'b1; x_ek = EK_ADEL; x_bad = va;
                end else begin
                    x_ld = 1'b1; x_lk = LK_LW; x_msize = MSZ_WORD; x_maddr = va[28:0];
                end
            end
            OP_LWL, OP_LWR: begin
                x_ld = 1'b1; x_lk = (op == OP_LWL) ? LK_LWL : LK_LWR;
                x_msize = MSZ_WORD; x_maddr = {va[28:2], 2'b00};
            end
            OP_SB: begin
                x_mop = MOP_WRITE; x_maddr = va[28:0]; x_msize = MSZ_BYTE;
                x_wdata = {24'b0, b[7:0]} << {lane, 3'b000};
                x_bmask = 4'b0001 << lane;
            end
            OP_SH: begin
                if (va[0]) begin
                    x_exc = 1'b1; x_ek = EK_ADES; x_bad = va;
                end else begin
                    x_mop = MOP_WRITE; x_maddr = va[28:0]; x_msize = MSZ_HALF;
                    x_wdata = {16'b0, b[15:0]} << {lane[1], 4'b0000};
                    x_bmask = 4'b0011 << {lane[1], 1'b0};
                end
            end
            OP_SW: begin
                if (!r_cp0[CP_SR][SR_ISC_BIT]) begin
                    if (va[1:0] != 2'b00) begin
                        x_exc = 1'b1; x_ek = EK_ADES; x_bad = va;
                    end else begin
                        x_mop = MOP_WRITE; x_maddr = va[28:0]; x_msize = MSZ_WORD;
                        x_wdata = b; x_bmask = 4'hF;
                    end
                end
            end
            OP_SWL: begin
                x_mop = MOP_WRITE; x_maddr = {va[28:2], 2'b00}; x_msize = MSZ_WORD;
                x_wdata = b >> (5'd24 - {lane, 3'b000});
                unique case (lane)
                    2'd0:    x_bmask = 4'b0001;
                    2'd1:    x_bmask = 4'b0011;
                    2'd2:    x_bmask = 4'b0111;
                    default: x_bmask = 4'b1111;
                endcase
            end
            OP_SWR: begin
                x_mop = MOP_WRITE; x_maddr = {va[28:2], 2'b00}; x_msize = MSZ_WORD;
                x_wdata = b << {lane, 3'b000};
                x_bmask = 4'hF << lane;
            end
            default: begin
                x_exc = 1'b1; x_ek = EK_RI;
            end
        endcase
        if (x_ld) x_mop = MOP_READ;
    end

    // load completion
    logic [2:0]  lk;
    logic [4:0]  lrt, lsh;
    logic [31:0] old, lv;
    logic [7:0]  lbyte;
    logic [15:0] lhalf;

    assign lk    = r_linfo[2:0];
    assign lrt   = r_linfo[7:3];
    assign lsh   = {r_linfo[9:8], 3'b000};
    assign old   = (r_nld_dst == lrt) ? r_nld_val : r_a;
    assign lbyte = 8'(r_ld >> lsh);
    assign lhalf = 16'(r_ld >> {lsh[4], 4'b0000});

    always_comb begin
        unique case (lk)
            LK_LB:   lv = {{24{lbyte[7]}}, lbyte};
            LK_LBU:  lv = {24'b0, lbyte};
            LK_LH:   lv = {{16{lhalf[15]}}, lhalf};
            LK_LHU:  lv = {16'b0, lhalf};
            LK_LW:   lv = r_ld;
            LK_LWL:  lv = (old & (32'h00FF_FFFF >> lsh)) | (r_ld << (5'd24 - lsh));
            default: lv = (old & (32'hFFFF_FF00 << (5'd24 - lsh))) | (r_ld >> lsh);
        endcase
    end

    // divider step
    logic [32:0] dsh, ddif;
    assign dsh  = {r_rem, r_dq[31]};
    assign ddif = dsh - {1'b0, r_dvs};

    logic [3:0]  ecode;
    logic        ehalt;
    assign ecode = exc_code(x_ek);
    assign ehalt = r_hmask[ecode];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hmask   <= '0;
            r_pc      <= RESET_PC;
            r_npc     <= RESET_PC + 32'd4;
            r_hi      <= '0;
            r_lo      <= '0;
            for (int i = 0; i < 32; i++) r_cp0[i] <= '0;
            r_nld_dst <= '0;
            r_nld_val <= '0;
            r_await   <= 1'b0;
            r_linfo   <= '0;
            r_gval    <= '0;
            r_raddr   <= '0;
            r_ov      <= 1'b0;
            r_wb_en   <= 1'b0;
            r_fl_en   <= 1'b0;
        end else begin
            r_raddr <= ram_raddr;
            if (i_cfg_we) r_hmask <= i_cfg_data;
            if (ram_we) r_gval[ram_waddr] <= 1'b1;
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (!i_in.kind && !r_await) begin
                            r_ir     <= i_in.instr_word;
                            r_ldpath <= 1'b0;
                            r_state  <= S_RS;
                        end else if (i_in.kind && r_await) begin
                            r_ld     <= i_in.read_data;
                            r_ldpath <= 1'b1;
                            r_state  <= S_RS;
                        end else begin
                            r_res            <= '0;
                            r_res.fetch_addr <= r_pc[28:0];
                            r_state          <= S_OUT;
                        end
                    end
                end
                S_RS: begin
                    r_a     <= rv;
                    r_state <= r_ldpath ? S_LEX : S_RT;
                end
                S_RT: begin
                    r_b     <= rv;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_res            <= '0;
                    r_res.mem_op     <= x_mop;
                    r_res.mem_addr   <= x_maddr;
                    r_res.mem_size   <= x_msize;
                    r_res.write_data <= x_wdata;
                    r_res.byte_mask  <= x_bmask;
                    r_res.exc_flag   <= x_exc;
                    r_res.exc_kind   <= x_exc ? x_ek : EK_ADEL;
                    r_res.exc_halted <= x_exc & ehalt;
                    r_wb_en   <= x_wb_en && x_wb_addr != '0;
                    r_wb_addr <= x_wb_addr;
                    r_wb_data <= x_wb_data;
                    if (x_exc && !ehalt) begin
                        r_cp0[CP_EPC]   <= r_pc;
                        r_cp0[CP_SR]    <= {r_cp0[CP_SR][31:6], r_cp0[CP_SR][3:0], 2'b00};
                        if (x_ek == EK_ADEL || x_ek == EK_ADES) r_cp0[CP_BADA] <= x_bad;
                        r_cp0[CP_CAUSE] <= {16'b0, r_cp0[CP_CAUSE][15:8], 2'b00, ecode, 2'b00};
                        r_pc             <= EXC_VEC;
                        r_npc            <= EXC_VEC + 32'd4;
                        r_res.fetch_addr <= EXC_VEC[28:0];
                    end else begin
                        r_pc             <= r_npc;
                        r_npc            <= x_npc;
                        r_res.fetch_addr <= r_npc[28:0];
                    end
                    if (x_cp_we) r_cp0[x_cp_idx] <= x_cp_data;
                    if (x_rfe) r_cp0[CP_SR] <= {r_cp0[CP_SR][31:4], r_cp0[CP_SR][5:2]};
                    if (x_hi_we) r_hi <= x_hi;
                    if (x_lo_we) r_lo <= x_lo;
                    if (x_mul) begin
                        r_hi <= prod[63:32];
                        r_lo <= prod[31:0];
                    end
                    r_dq   <= (fn == FN_DIV && a[31]) ? -a : a;
                    r_dvs  <= (fn == FN_DIV && b[31]) ? -b : b;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_qneg <= (fn == FN_DIV) && (a[31] ^ b[31]);
                    r_rneg <= (fn == FN_DIV) && a[31];
                    if (x_ld) begin
                        r_await <= 1'b1;
                        r_linfo <= {lane, rt, x_lk};
                        r_fl_en <= 1'b0;
                    end else begin
                        r_fl_en   <= r_nld_dst != '0;
                        r_fl_addr <= r_nld_dst;
                        r_fl_data <= r_nld_val;
                        r_nld_dst <= '0;
                        r_nld_val <= '0;
                    end
                    r_state <= x_div ? S_DIV : S_WB;
                end
                S_DIV: begin
                    if (!ddif[32]) begin
                        r_rem <= ddif[31:0];
                        r_dq  <= {r_dq[30:0], 1'b1};
                    end else begin
                        r_rem <= dsh[31:0];
                        r_dq  <= {r_dq[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_state <= S_DIVF;
                end
                S_DIVF: begin
                    r_lo    <= r_qneg ? -r_dq : r_dq;
                    r_hi    <= r_rneg ? -r_rem : r_rem;
                    r_state <= S_WB;
                end
                S_LEX: begin
                    r_res            <= '0;
                    r_res.fetch_addr <= r_pc[28:0];
                    r_wb_en   <= 1'b0;
                    r_fl_en   <= r_nld_dst != '0 && r_nld_dst != lrt;
                    r_fl_addr <= r_nld_dst;
                    r_fl_data <= r_nld_val;
                    r_nld_dst <= lrt;
                    r_nld_val <= lv;
                    r_await   <= 1'b0;
                    r_state   <= S_WB;
                end
                S_WB: r_state <= S_FL;
                S_FL: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ov || i_out_ready) begin
                        r_out   <= r_res;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ram_waddr != '0)
        else $error("write to GPR zero");
    a_halt_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.exc_halted) |-> o_out.exc_flag)
        else $error("halted without exception");
    a_store_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.mem_op == MOP_WRITE) |-> o_out.byte_mask != '0)
        else $error("store with empty mask");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_dvs != '0)
        else $error("divider running on zero divisor");
endmodule
